>>> src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// shared widths, opcodes and stage counts of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    // word format, signed q16.16
    localparam int W  = 32;
    localparam int F  = 16;
    // full product width
    localparam int PW = 2 * W;
    // quotient and root bits produced by the iterative units
    localparam int QB = W;
    // bits resolved per pipeline stage in divider and square root
    localparam int BITS_PER_STAGE = 4;
    localparam int UNIT_STAGES    = QB / BITS_PER_STAGE;
    // square root partial remainder width
    localparam int RW = QB + 4;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_CONJ   = 4'd4,
        OP_ABS    = 4'd5,
        OP_ABS2   = 4'd6,
        OP_WITHIN = 4'd7,
        OP_EQUAL  = 4'd8
    } op_t;

endpackage

>>> src/cau_mult.sv
// ----------------------------------------------------------------------------
// cau_mult
// registered bank of six signed word products for mul, div and magnitude
// ----------------------------------------------------------------------------
module cau_mult
(
    input  logic                             clk,
    input  logic                             sq_sel,
    input  logic signed [cau_pkg::W-1:0]     ar,
    input  logic signed [cau_pkg::W-1:0]     ai,
    input  logic signed [cau_pkg::W-1:0]     br,
    input  logic signed [cau_pkg::W-1:0]     bi,
    output logic signed [cau_pkg::PW-1:0]    p0,
    output logic signed [cau_pkg::PW-1:0]    p1,
    output logic signed [cau_pkg::PW-1:0]    p2,
    output logic signed [cau_pkg::PW-1:0]    p3,
    output logic signed [cau_pkg::PW-1:0]    p4,
    output logic signed [cau_pkg::PW-1:0]    p5
);
    import cau_pkg::*;

    logic signed [W-1:0]  br_m;
    logic signed [W-1:0]  bi_m;
    logic signed [PW-1:0] p0_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [PW-1:0] p3_reg;
    logic signed [PW-1:0] p4_reg;
    logic signed [PW-1:0] p5_reg;

    // magnitude ops square a instead of taking a times b
    assign br_m = sq_sel ? ar : br;
    assign bi_m = sq_sel ? ai : bi;

    // products
    always_ff @(posedge clk)
    begin
        p0_reg <= ar * br_m;
        p1_reg <= ai * bi_m;
        p2_reg <= ar * bi;
        p3_reg <= ai * br;
        p4_reg <= br * br;
        p5_reg <= bi * bi;
    end

    assign p0 = p0_reg;
    assign p1 = p1_reg;
    assign p2 = p2_reg;
    assign p3 = p3_reg;
    assign p4 = p4_reg;
    assign p5 = p5_reg;

endmodule

>>> src/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div
// pipelined restoring divider, two lanes sharing one divisor, with
// overflow detect for quotients of 2^QB and above
// ----------------------------------------------------------------------------
module cau_div
(
    input  logic                       clk,
    input  logic [cau_pkg::PW-1:0]     num_re,
    input  logic [cau_pkg::PW-1:0]     num_im,
    input  logic [cau_pkg::PW-1:0]     den,
    output logic [cau_pkg::QB-1:0]     q_re,
    output logic [cau_pkg::QB-1:0]     q_im,
    output logic                       ovf_re,
    output logic                       ovf_im
);
    import cau_pkg::*;

    localparam int XW = PW + QB;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [QB-1:0] q;
        logic [QB-1:0] lo;
    } div_lane_t;

    div_lane_t     re_reg  [0:UNIT_STAGES];
    div_lane_t     im_reg  [0:UNIT_STAGES];
    logic [PW-1:0] den_reg [0:UNIT_STAGES];
    logic          ovf_re_reg [0:UNIT_STAGES];
    logic          ovf_im_reg [0:UNIT_STAGES];

    // BITS_PER_STAGE quotient bits of one lane
    function automatic div_lane_t lane_step(input div_lane_t l, input logic [PW-1:0] d);
        div_lane_t   r;
        logic [PW:0] t;
        r = l;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            t    = {r.rem, r.lo[QB-1]};
            r.lo = {r.lo[QB-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t   = t - {1'b0, d};
                r.q = {r.q[QB-2:0], 1'b1};
            end
            else
            begin
                r.q = {r.q[QB-2:0], 1'b0};
            end
            r.rem = t[PW-1:0];
        end
        return r;
    endfunction

    // prepare: dividend is num shifted up by F, overflow if quotient >= 2^QB
    always_ff @(posedge clk)
    begin
        re_reg[0].rem <= {{F{1'b0}}, num_re[PW-1:F]};
        re_reg[0].q   <= '0;
        re_reg[0].lo  <= {num_re[F-1:0], {(QB-F){1'b0}}};
        im_reg[0].rem <= {{F{1'b0}}, num_im[PW-1:F]};
        im_reg[0].q   <= '0;
        im_reg[0].lo  <= {num_im[F-1:0], {(QB-F){1'b0}}};
        den_reg[0]    <= den;
        ovf_re_reg[0] <= XW'({{(QB-F){1'b0}}, num_re, {F{1'b0}}}) >= {den, {QB{1'b0}}};
        ovf_im_reg[0] <= XW'({{(QB-F){1'b0}}, num_im, {F{1'b0}}}) >= {den, {QB{1'b0}}};
    end

    // iteration stages
    for (genvar g = 0; g < UNIT_STAGES; g++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            re_reg[g+1]     <= lane_step(re_reg[g], den_reg[g]);
            im_reg[g+1]     <= lane_step(im_reg[g], den_reg[g]);
            den_reg[g+1]    <= den_reg[g];
            ovf_re_reg[g+1] <= ovf_re_reg[g];
            ovf_im_reg[g+1] <= ovf_im_reg[g];
        end
    end

    assign q_re   = re_reg[UNIT_STAGES].q;
    assign q_im   = im_reg[UNIT_STAGES].q;
    assign ovf_re = ovf_re_reg[UNIT_STAGES];
    assign ovf_im = ovf_im_reg[UNIT_STAGES];

endmodule

>>> src/cau_sqrt.sv
// ----------------------------------------------------------------------------
// cau_sqrt
// pipelined digit-by-digit integer square root, rounded down
// ----------------------------------------------------------------------------
module cau_sqrt
(
    input  logic                       clk,
    input  logic [cau_pkg::PW-1:0]     x,
    output logic [cau_pkg::QB-1:0]     root
);
    import cau_pkg::*;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] root;
        logic [PW-1:0] xs;
    } sqrt_lane_t;

    sqrt_lane_t lane_reg [0:UNIT_STAGES];

    // BITS_PER_STAGE root bits, two radicand bits each
    function automatic sqrt_lane_t lane_step(input sqrt_lane_t l);
        sqrt_lane_t    r;
        logic [RW-1:0] t;
        logic [RW-1:0] trial;
        r = l;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            t     = {r.rem[RW-3:0], r.xs[PW-1:PW-2]};
            trial = {{(RW-QB-2){1'b0}}, r.root, 2'b01};
            r.xs  = {r.xs[PW-3:0], 2'b00};
            if (t >= trial)
            begin
                r.rem  = t - trial;
                r.root = {r.root[QB-2:0], 1'b1};
            end
            else
            begin
                r.rem  = t;
                r.root = {r.root[QB-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // load radicand
    always_ff @(posedge clk)
    begin
        lane_reg[0].rem  <= '0;
        lane_reg[0].root <= '0;
        lane_reg[0].xs   <= x;
    end

    // iteration stages
    for (genvar g = 0; g < UNIT_STAGES; g++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            lane_reg[g+1] <= lane_step(lane_reg[g]);
        end
    end

    assign root = lane_reg[UNIT_STAGES].root;

endmodule

>>> src/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// every opcode: done after stages a-d, divider/sqrt stages and output register
// throughput: one beat per cycle, busy never rises
// the divider and square root are 8-stage pipelines, 4 bits per stage
// reset clears the valid bits and the done strobe; data registers are not reset
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [3:0]                     op,
    input  logic signed [cau_pkg::W-1:0]   a_re,
    input  logic signed [cau_pkg::W-1:0]   a_im,
    input  logic signed [cau_pkg::W-1:0]   b_re,
    input  logic signed [cau_pkg::W-1:0]   b_im,
    input  logic [cau_pkg::W-2:0]          tolerance,
    output logic                           done,
    output logic signed [cau_pkg::W-1:0]   res_re,
    output logic signed [cau_pkg::W-1:0]   res_im,
    output logic                           match,
    output logic                           saturated,
    output logic                           divide_by_zero
);
    import cau_pkg::*;

    localparam int XS = PW + 1;
    localparam logic signed [XS-1:0] WIDE_MAX = (XS'(1) <<< (W-1)) - XS'(1);
    localparam logic signed [XS-1:0] WIDE_MIN = ~WIDE_MAX;
    localparam logic signed [W-1:0]  WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  WORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [QB-1:0]        Q_HALF   = {1'b1, {(QB-1){1'b0}}};

    typedef struct packed {
        logic                sat;
        logic signed [W-1:0] val;
    } sat_res_t;

    typedef struct packed {
        op_t                 op;
        logic signed [W-1:0] simp_re;
        logic signed [W-1:0] simp_im;
        logic                simp_match;
        logic                simp_sat;
        sat_res_t            mul_re;
        sat_res_t            mul_im;
        sat_res_t            abs2;
        logic                neg_re;
        logic                neg_im;
        logic                dz;
    } side_t;

    // clip a wide signed value to the word range
    function automatic sat_res_t sat_word(input logic signed [XS-1:0] v);
        sat_res_t r;
        if (v > WIDE_MAX)
        begin
            r.sat = 1'b1;
            r.val = WORD_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            r.sat = 1'b1;
            r.val = WORD_MIN;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = v[W-1:0];
        end
        return r;
    endfunction

    // signed quotient from magnitude, sign and overflow
    function automatic sat_res_t div_sat(input logic [QB-1:0] q, input logic ovf,
                                         input logic neg);
        sat_res_t r;
        if (neg)
        begin
            if (ovf || (q > Q_HALF))
            begin
                r.sat = 1'b1;
                r.val = WORD_MIN;
            end
            else
            begin
                r.sat = 1'b0;
                r.val = W'(~q + 1'b1);
            end
        end
        else
        begin
            if (ovf || q[QB-1])
            begin
                r.sat = 1'b1;
                r.val = WORD_MAX;
            end
            else
            begin
                r.sat = 1'b0;
                r.val = W'(q);
            end
        end
        return r;
    endfunction

    // stage a: input capture
    logic                v_a_reg;
    op_t                 op_a_reg;
    logic signed [W-1:0] ar_a_reg;
    logic signed [W-1:0] ai_a_reg;
    logic signed [W-1:0] br_a_reg;
    logic signed [W-1:0] bi_a_reg;
    logic [W-2:0]        tol_a_reg;

    // stage b: products and simple ops
    logic                 v_b_reg;
    op_t                  op_b_reg;
    logic signed [W-1:0]  simp_re_next, simp_re_b_reg;
    logic signed [W-1:0]  simp_im_next, simp_im_b_reg;
    logic                 simp_match_next, simp_match_b_reg;
    logic                 simp_sat_next, simp_sat_b_reg;
    logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
    logic                 sq_sel;

    // stage c: sums
    logic                 v_c_reg;
    op_t                  op_c_reg;
    logic signed [W-1:0]  simp_re_c_reg;
    logic signed [W-1:0]  simp_im_c_reg;
    logic                 simp_match_c_reg;
    logic                 simp_sat_c_reg;
    logic signed [XS-1:0] sm_re_c_reg;
    logic signed [XS-1:0] sm_im_c_reg;
    logic signed [XS-1:0] n_re_c_reg;
    logic signed [XS-1:0] n_im_c_reg;
    logic [PW-1:0]        d_c_reg;

    // stage d: clipped products, magnitudes
    logic                 v_d_reg;
    side_t                side_d_reg;
    logic [PW-1:0]        nmag_re_d_reg;
    logic [PW-1:0]        nmag_im_d_reg;
    logic [PW-1:0]        den_d_reg;
    logic [PW-1:0]        x_d_reg;
    logic [XS-1:0]        nmag_re_next;
    logic [XS-1:0]        nmag_im_next;

    // delay line alongside the divider and square root
    logic                 v_line_reg    [0:UNIT_STAGES];
    side_t                side_line_reg [0:UNIT_STAGES];

    logic [QB-1:0]        q_re, q_im, root;
    logic                 ovf_re, ovf_im;

    // final select
    side_t                fs;
    sat_res_t             dre, dim;
    logic signed [W-1:0]  res_re_next, res_im_next;
    logic                 match_next, saturated_next, dz_next;
    logic                 done_reg;
    logic signed [W-1:0]  res_re_reg, res_im_reg;
    logic                 match_reg, saturated_reg, dz_reg;

    // simple op wires
    sat_res_t             add_re, add_im, sub_re, sub_im;
    logic signed [XS-1:0] arx, aix, brx, bix, diff_re, diff_im;
    logic [XS-1:0]        dm_re, dm_im;

    assign busy = 1'b0;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
            for (int i = 0; i <= UNIT_STAGES; i++)
            begin
                v_line_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            v_a_reg       <= start;
            v_b_reg       <= v_a_reg;
            v_c_reg       <= v_b_reg;
            v_d_reg       <= v_c_reg;
            v_line_reg[0] <= v_d_reg;
            for (int i = 1; i <= UNIT_STAGES; i++)
            begin
                v_line_reg[i] <= v_line_reg[i-1];
            end
            done_reg <= v_line_reg[UNIT_STAGES];
        end
    end

    // stage a capture
    always_ff @(posedge clk)
    begin
        op_a_reg  <= op_t'(op);
        ar_a_reg  <= a_re;
        ai_a_reg  <= a_im;
        br_a_reg  <= b_re;
        bi_a_reg  <= b_im;
        tol_a_reg <= tolerance;
    end

    // products
    assign sq_sel = (op_a_reg == OP_ABS) || (op_a_reg == OP_ABS2);

    cau_mult u_mult
    (
        .clk    (clk),
        .sq_sel (sq_sel),
        .ar     (ar_a_reg),
        .ai     (ai_a_reg),
        .br     (br_a_reg),
        .bi     (bi_a_reg),
        .p0     (p0),
        .p1     (p1),
        .p2     (p2),
        .p3     (p3),
        .p4     (p4),
        .p5     (p5)
    );

    // add, sub, conj and compares
    assign arx     = XS'(ar_a_reg);
    assign aix     = XS'(ai_a_reg);
    assign brx     = XS'(br_a_reg);
    assign bix     = XS'(bi_a_reg);
    assign add_re  = sat_word(arx + brx);
    assign add_im  = sat_word(aix + bix);
    assign sub_re  = sat_word(arx - brx);
    assign sub_im  = sat_word(aix - bix);
    assign diff_re = arx - brx;
    assign diff_im = aix - bix;
    assign dm_re   = diff_re[XS-1] ? (~diff_re + 1'b1) : diff_re;
    assign dm_im   = diff_im[XS-1] ? (~diff_im + 1'b1) : diff_im;

    always_comb
    begin
        simp_re_next    = '0;
        simp_im_next    = '0;
        simp_match_next = 1'b0;
        simp_sat_next   = 1'b0;
        unique case (op_a_reg)
            OP_ADD:
            begin
                simp_re_next  = add_re.val;
                simp_im_next  = add_im.val;
                simp_sat_next = add_re.sat | add_im.sat;
            end
            OP_SUB:
            begin
                simp_re_next  = sub_re.val;
                simp_im_next  = sub_im.val;
                simp_sat_next = sub_re.sat | sub_im.sat;
            end
            OP_CONJ:
            begin
                simp_re_next = ar_a_reg;
                if (ai_a_reg == WORD_MIN)
                begin
                    simp_im_next  = WORD_MAX;
                    simp_sat_next = 1'b1;
                end
                else
                begin
                    simp_im_next = -ai_a_reg;
                end
            end
            OP_WITHIN:
            begin
                simp_match_next = (dm_re <= XS'(tol_a_reg)) && (dm_im <= XS'(tol_a_reg));
            end
            OP_EQUAL:
            begin
                simp_match_next = (ar_a_reg == br_a_reg) && (ai_a_reg == bi_a_reg);
            end
            default:
            begin
                simp_match_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_b_reg         <= op_a_reg;
        simp_re_b_reg    <= simp_re_next;
        simp_im_b_reg    <= simp_im_next;
        simp_match_b_reg <= simp_match_next;
        simp_sat_b_reg   <= simp_sat_next;
    end

    // stage c: exact sums of products
    always_ff @(posedge clk)
    begin
        op_c_reg         <= op_b_reg;
        simp_re_c_reg    <= simp_re_b_reg;
        simp_im_c_reg    <= simp_im_b_reg;
        simp_match_c_reg <= simp_match_b_reg;
        simp_sat_c_reg   <= simp_sat_b_reg;
        sm_re_c_reg      <= XS'(p0) - XS'(p1);
        sm_im_c_reg      <= XS'(p2) + XS'(p3);
        n_re_c_reg       <= XS'(p0) + XS'(p1);
        n_im_c_reg       <= XS'(p3) - XS'(p2);
        d_c_reg          <= $unsigned(p4) + $unsigned(p5);
    end

    // stage d: floor shift and clip, dividend magnitudes
    assign nmag_re_next = n_re_c_reg[XS-1] ? (~n_re_c_reg + 1'b1) : n_re_c_reg;
    assign nmag_im_next = n_im_c_reg[XS-1] ? (~n_im_c_reg + 1'b1) : n_im_c_reg;

    always_ff @(posedge clk)
    begin
        side_d_reg.op         <= op_c_reg;
        side_d_reg.simp_re    <= simp_re_c_reg;
        side_d_reg.simp_im    <= simp_im_c_reg;
        side_d_reg.simp_match <= simp_match_c_reg;
        side_d_reg.simp_sat   <= simp_sat_c_reg;
        side_d_reg.mul_re     <= sat_word(sm_re_c_reg >>> F);
        side_d_reg.mul_im     <= sat_word(sm_im_c_reg >>> F);
        side_d_reg.abs2       <= sat_word(n_re_c_reg >>> F);
        side_d_reg.neg_re     <= n_re_c_reg[XS-1];
        side_d_reg.neg_im     <= n_im_c_reg[XS-1];
        side_d_reg.dz         <= (d_c_reg == '0);
        nmag_re_d_reg         <= nmag_re_next[PW-1:0];
        nmag_im_d_reg         <= nmag_im_next[PW-1:0];
        den_d_reg             <= d_c_reg;
        x_d_reg               <= n_re_c_reg[PW-1:0];
    end

    // divider and square root
    cau_div u_div
    (
        .clk    (clk),
        .num_re (nmag_re_d_reg),
        .num_im (nmag_im_d_reg),
        .den    (den_d_reg),
        .q_re   (q_re),
        .q_im   (q_im),
        .ovf_re (ovf_re),
        .ovf_im (ovf_im)
    );

    cau_sqrt u_sqrt
    (
        .clk  (clk),
        .x    (x_d_reg),
        .root (root)
    );

    // sideband delay matching the units
    always_ff @(posedge clk)
    begin
        side_line_reg[0] <= side_d_reg;
        for (int i = 1; i <= UNIT_STAGES; i++)
        begin
            side_line_reg[i] <= side_line_reg[i-1];
        end
    end

    // result select
    assign fs  = side_line_reg[UNIT_STAGES];
    assign dre = div_sat(q_re, ovf_re, fs.neg_re);
    assign dim = div_sat(q_im, ovf_im, fs.neg_im);

    always_comb
    begin
        res_re_next    = '0;
        res_im_next    = '0;
        match_next     = 1'b0;
        saturated_next = 1'b0;
        dz_next        = 1'b0;
        unique case (fs.op)
            OP_ADD, OP_SUB, OP_CONJ, OP_WITHIN, OP_EQUAL:
            begin
                res_re_next    = fs.simp_re;
                res_im_next    = fs.simp_im;
                match_next     = fs.simp_match;
                saturated_next = fs.simp_sat;
            end
            OP_MUL:
            begin
                res_re_next    = fs.mul_re.val;
                res_im_next    = fs.mul_im.val;
                saturated_next = fs.mul_re.sat | fs.mul_im.sat;
            end
            OP_DIV:
            begin
                if (fs.dz)
                begin
                    dz_next = 1'b1;
                end
                else
                begin
                    res_re_next    = dre.val;
                    res_im_next    = dim.val;
                    saturated_next = dre.sat | dim.sat;
                end
            end
            OP_ABS:
            begin
                if (root[QB-1])
                begin
                    res_re_next    = WORD_MAX;
                    saturated_next = 1'b1;
                end
                else
                begin
                    res_re_next = W'(root);
                end
            end
            OP_ABS2:
            begin
                res_re_next    = fs.abs2.val;
                saturated_next = fs.abs2.sat;
            end
            default:
            begin
                res_re_next = '0;
            end
        endcase
    end

    // output beat
    always_ff @(posedge clk)
    begin
        res_re_reg    <= res_re_next;
        res_im_reg    <= res_im_next;
        match_reg     <= match_next;
        saturated_reg <= saturated_next;
        dz_reg        <= dz_next;
    end

    assign done           = done_reg;
    assign res_re         = res_re_reg;
    assign res_im         = res_im_reg;
    assign match          = match_reg;
    assign saturated      = saturated_reg;
    assign divide_by_zero = dz_reg;

endmodule
